// ===== rtl/bmhq_pkg.sv =====
package bmhq_pkg;

  localparam int unsigned KEY_W = 31;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] min_value;
    logic             was_empty;
  } out_word_t;

  typedef struct packed {
    logic accept_push;
    logic accept_pop;
    logic pop_load;
    logic rd_parent;
    logic rd_kids;
    logic up_step;
    logic dn_step;
    logic place_key;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic cur_root;
    logic up_move;
    logic has_kid;
    logic dn_move;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/bmhq_ctrl.sv =====
module bmhq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_opcode_i,
  output logic              in_ready_o,
  input  bmhq_pkg::sts_t    sts_i,
  output bmhq_pkg::cmd_t    cmd_o
);
  import bmhq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_POP_LD,
    ST_DN_CHK,
    ST_DN_CMP,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_opcode_i == OP_PUSH) begin
            if (!sts_i.full) begin
              cmd_o.accept_push = 1'b1;
              state_d           = ST_UP_CHK;
            end
          end else begin
            cmd_o.accept_pop = 1'b1;
            state_d          = sts_i.empty ? ST_OUT : ST_POP_LD;
          end
        end
      end
      ST_UP_CHK: begin
        if (sts_i.cur_root) begin
          cmd_o.place_key = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.rd_parent = 1'b1;
          state_d         = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (sts_i.up_move) begin
          cmd_o.up_step = 1'b1;
          state_d       = ST_UP_CHK;
        end else begin
          cmd_o.place_key = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_POP_LD: begin
        cmd_o.pop_load = 1'b1;
        state_d        = ST_DN_CHK;
      end
      ST_DN_CHK: begin
        if (sts_i.has_kid) begin
          cmd_o.rd_kids = 1'b1;
          state_d       = ST_DN_CMP;
        end else begin
          cmd_o.place_key = 1'b1;
          state_d         = ST_OUT;
        end
      end
      ST_DN_CMP: begin
        if (sts_i.dn_move) begin
          cmd_o.dn_step = 1'b1;
          state_d       = ST_DN_CHK;
        end else begin
          cmd_o.place_key = 1'b1;
          state_d         = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/bmhq_dp.sv =====
module bmhq_dp #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmhq_pkg::in_word_t  in_word_i,
  input  bmhq_pkg::cmd_t      cmd_i,
  output bmhq_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bmhq_pkg::out_word_t out_word_o
);
  import bmhq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [KEY_W-1:0] mem [CAPACITY];

  logic [CW-1:0]    count_q;
  logic [CW-1:0]    cur_q;
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] top_q;
  logic             empty_q;
  logic [KEY_W-1:0] rd_a_q, rd_b_q;
  logic             out_valid_q;
  out_word_t        out_word_q;

  logic [CW-1:0]    par;
  logic [CW-1:0]    par_m1;
  logic [CW-1:0]    cur_m1;
  logic [CW-1:0]    last_m1;
  logic [CW:0]      kid_l, kid_r, kid_pos;
  logic             right_ok, use_right;
  logic [KEY_W-1:0] kid_val;
  logic [AW-1:0]    rd_addr_a, rd_addr_b, wr_addr;
  logic             wr_en;
  logic [KEY_W-1:0] wr_data;

  assign par       = cur_q >> 1;
  assign par_m1    = par - 1'b1;
  assign cur_m1    = cur_q - 1'b1;
  assign last_m1   = count_q - 1'b1;
  assign kid_l     = {cur_q, 1'b0};
  assign kid_r     = {cur_q, 1'b1};
  assign right_ok  = (kid_r <= {1'b0, count_q});
  assign use_right = right_ok && (rd_a_q > rd_b_q);
  assign kid_val   = use_right ? rd_b_q : rd_a_q;
  assign kid_pos   = use_right ? kid_r : kid_l;

  always_comb begin
    rd_addr_a = '0;
    rd_addr_b = last_m1[AW-1:0];
    if (cmd_i.rd_parent) begin
      rd_addr_a = par_m1[AW-1:0];
    end else if (cmd_i.rd_kids) begin
      rd_addr_a = cur_m1[AW-1:0] + cur_q[AW-1:0];
      rd_addr_b = kid_l[AW-1:0];
    end
  end

  assign wr_en   = cmd_i.up_step | cmd_i.dn_step | cmd_i.place_key;
  assign wr_addr = cur_m1[AW-1:0];
  assign wr_data = cmd_i.place_key ? key_q : (cmd_i.up_step ? rd_a_q : kid_val);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_q <= mem[rd_addr_a];
    rd_b_q <= mem[rd_addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.accept_push) begin
      count_q <= count_q + 1'b1;
    end else if (cmd_i.accept_pop && !sts_o.empty) begin
      count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_push) begin
      cur_q <= count_q + 1'b1;
      key_q <= in_word_i.value;
    end else if (cmd_i.accept_pop) begin
      cur_q   <= CW'(1);
      empty_q <= sts_o.empty;
      top_q   <= '0;
    end else if (cmd_i.pop_load) begin
      top_q <= rd_a_q;
      key_q <= rd_b_q;
    end else if (cmd_i.up_step) begin
      cur_q <= par;
    end else if (cmd_i.dn_step) begin
      cur_q <= kid_pos[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_word_q.min_value <= top_q;
      out_word_q.was_empty <= empty_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign sts_o.full     = (count_q == CW'(CAPACITY));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.cur_root = (cur_q == CW'(1));
  assign sts_o.up_move  = (rd_a_q > key_q);
  assign sts_o.has_kid  = (kid_l <= {1'b0, count_q});
  assign sts_o.dn_move  = (key_q > kid_val);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept_push |-> !sts_o.full)
    else $error("push taken on full heap");

  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> sts_o.out_free)
    else $error("result word overwritten");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept_pop && !sts_o.empty) |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop did not drop entry count");

endmodule

// ===== rtl/binary_min_heap_queue.sv =====
// Channel | Direction | Handshake                      | Word
// in      | input     | in_valid_i / in_ready_o        | in_word_i  (opcode, value)
// out     | output    | out_valid_o / out_ready_i      | out_word_o (min_value, was_empty)
//
// Push: the key climbs while its parent is greater, then is placed at the root or
//   below the first parent that is not greater.
// Pop: an empty heap goes straight to the result; else the last entry sifts down
//   from the root into the smaller child, and the result waits for a free output.
// Each level costs one registered read of the single-write store, then a write.
// Reset empties the heap at once; the store itself is never cleared.
// A held result word does not block sifting; only loading the next result waits.
module binary_min_heap_queue #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bmhq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bmhq_pkg::out_word_t out_word_o
);
  import bmhq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_word_i.opcode),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bmhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== tb/tb_binary_min_heap_queue.sv =====
module tb_binary_min_heap_queue;
  import bmhq_pkg::*;

  localparam int unsigned CAP = 1024;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  localparam int unsigned MAX_REPORTS = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;

  logic steady = 1'b0;
  int unsigned error_count = 0;
  int unsigned n_push = 0;
  int unsigned n_dropped = 0;
  int unsigned n_pop = 0;
  int unsigned n_empty_pop = 0;

  logic [KEY_W-1:0] heap_img [1:CAP];
  int unsigned heap_len = 0;
  out_word_t pending_mins[$];

  binary_min_heap_queue #(
    .CAPACITY(CAP)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 8);
  end

  function automatic void heap_insert(input logic [KEY_W-1:0] key);
    int unsigned cur;
    int unsigned par;
    logic [KEY_W-1:0] tmp;
    if (heap_len >= CAP) begin
      n_dropped++;
      return;
    end
    heap_len++;
    cur = heap_len;
    heap_img[cur] = key;
    while (cur > 1) begin
      par = cur / 2;
      if (heap_img[par] <= heap_img[cur]) break;
      tmp = heap_img[par];
      heap_img[par] = heap_img[cur];
      heap_img[cur] = tmp;
      cur = par;
    end
  endfunction

  function automatic out_word_t heap_extract_min();
    out_word_t res;
    int unsigned cur;
    int unsigned kid;
    logic [KEY_W-1:0] tmp;
    res = '0;
    if (heap_len == 0) begin
      res.was_empty = 1'b1;
      return res;
    end
    res.min_value = heap_img[1];
    heap_img[1] = heap_img[heap_len];
    heap_len--;
    cur = 1;
    while (cur <= heap_len / 2) begin
      kid = 2 * cur;
      if (kid + 1 <= heap_len && heap_img[kid] > heap_img[kid + 1]) kid++;
      if (heap_img[cur] <= heap_img[kid]) break;
      tmp = heap_img[cur];
      heap_img[cur] = heap_img[kid];
      heap_img[kid] = tmp;
      cur = kid;
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] draw_key(input int unsigned mode);
    logic [31:0] r;
    r = $urandom;
    case (mode)
      0: return r[KEY_W-1:0];
      1: return KEY_W'($urandom_range(0, 15));
      default: return KEY_MAX - KEY_W'($urandom_range(0, 15));
    endcase
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic op, input logic [KEY_W-1:0] key);
    if (!steady && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < 8) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word.opcode <= op;
    in_word.value <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_PUSH) begin
      n_push++;
      heap_insert(key);
    end else begin
      n_pop++;
      if (heap_len == 0) n_empty_pop++;
      pending_mins.push_back(heap_extract_min());
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (out_valid && out_ready) begin
      if (pending_mins.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected word expected none actual min_value %0d was_empty %0b",
                   $time, out_word.min_value, out_word.was_empty);
      end else begin
        want = pending_mins.pop_front();
        if (out_word.min_value !== want.min_value) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: min_value mismatch expected %0d actual %0d",
                     $time, want.min_value, out_word.min_value);
        end
        if (out_word.was_empty !== want.was_empty) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: was_empty mismatch expected %0b actual %0b",
                     $time, want.was_empty, out_word.was_empty);
        end
      end
    end
  end

  task automatic check_empty_pops();
    send_word(OP_POP, '0);
    send_word(OP_POP, KEY_MAX);
  endtask

  task automatic check_key_extremes();
    send_word(OP_PUSH, KEY_MAX);
    send_word(OP_PUSH, '0);
    send_word(OP_PUSH, KEY_W'(1));
    send_word(OP_PUSH, KEY_MAX - KEY_W'(1));
    send_word(OP_PUSH, KEY_W'(31'h5555_5555));
    send_word(OP_PUSH, KEY_W'(31'h2AAA_AAAA));
    repeat (6) send_word(OP_POP, KEY_W'(31'h2AAA_AAAA));
    send_word(OP_POP, '0);
  endtask

  task automatic check_equal_keys();
    send_word(OP_PUSH, KEY_W'(7));
    send_word(OP_PUSH, KEY_W'(7));
    send_word(OP_PUSH, KEY_W'(3));
    send_word(OP_PUSH, KEY_W'(7));
    send_word(OP_PUSH, KEY_W'(3));
    repeat (5) send_word(OP_POP, KEY_W'(5));
  endtask

  task automatic check_random_traffic(input int unsigned n_chunks);
    int unsigned push_pct;
    int unsigned key_mode;
    logic [KEY_W-1:0] key;
    for (int c = 0; c < n_chunks; c++) begin
      push_pct = $urandom_range(20, 85);
      key_mode = $urandom_range(0, 2);
      steady = (c == 2 || c == 3);
      for (int i = 0; i < 50; i++) begin
        key = draw_key(key_mode);
        if ($urandom_range(0, 99) < push_pct) send_word(OP_PUSH, key);
        else send_word(OP_POP, key);
      end
    end
    steady = 1'b0;
  endtask

  task automatic check_full_heap();
    while (heap_len < CAP) send_word(OP_PUSH, draw_key($urandom_range(0, 2)));
    // drop: heap is full
    send_word(OP_PUSH, '0);
    send_word(OP_PUSH, '0);
    send_word(OP_PUSH, KEY_MAX);
    send_word(OP_PUSH, draw_key(0));
    repeat (8) send_word(OP_POP, draw_key(0));
    while (heap_len < CAP) send_word(OP_PUSH, draw_key(1));
    send_word(OP_PUSH, '0);
    repeat (8) send_word(OP_POP, draw_key(0));
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    check_empty_pops();
    check_key_extremes();
    check_equal_keys();
    check_random_traffic(12);
    check_full_heap();
    in_valid <= 1'b0;
    while (pending_mins.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d pushes (%0d dropped on a full heap) and %0d pops (%0d on an empty heap)",
             n_push, n_dropped, n_pop, n_empty_pop);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Timed out with %0d words outstanding", pending_mins.size());
    $display("FAIL");
    $finish;
  end

endmodule
